[design/mblp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mblp_pkg
// Types and constants for the multibase integer literal parser.
// ----------------------------------------------------------------------------
package mblp_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_NUMBER = 3'd2,
    PH_SUFFIX = 3'd3,
    PH_STRING = 3'd4,
    PH_NONNUM = 3'd5,
    PH_UNSUP  = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_NONNUM = 2'd2;
  localparam logic [1:0] KIND_UNSUP  = 2'd3;

  localparam logic [2:0] BASE_2    = 3'd0;
  localparam logic [2:0] BASE_4    = 3'd1;
  localparam logic [2:0] BASE_8    = 3'd2;
  localparam logic [2:0] BASE_10   = 3'd3;
  localparam logic [2:0] BASE_16   = 3'd4;
  localparam logic [2:0] BASE_NONE = 3'd5;

  localparam logic [4:0] DEFAULT_BASE_RST = 5'd10;
  localparam logic [4:0] DIGIT_NONE       = 5'd16;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] HEX_A    = 8'h0a;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  kind;
    logic [2:0]  base_used;
    logic        has_suffix;
    logic [7:0]  suffix_start;
  } out_item_t;

  function automatic logic [2:0] code_of_radix(input logic [4:0] r);
    logic [2:0] code;
    unique case (r)
      5'd2:    code = BASE_2;
      5'd4:    code = BASE_4;
      5'd8:    code = BASE_8;
      5'd10:   code = BASE_10;
      5'd16:   code = BASE_16;
      default: code = BASE_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [4:0] radix_of_code(input logic [2:0] code);
    logic [4:0] r;
    unique case (code)
      BASE_4:  r = 5'd4;
      BASE_8:  r = 5'd8;
      BASE_10: r = 5'd10;
      BASE_16: r = 5'd16;
      default: r = 5'd2;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + HEX_A;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + HEX_A;
    end else begin
      d = {3'd0, DIGIT_NONE};
    end
    return d[4:0];
  endfunction

  function automatic logic [63:0] mul_add(input logic [63:0] acc,
                                          input logic [2:0]  code,
                                          input logic [4:0]  d);
    logic [63:0] p;
    unique case (code)
      BASE_4:  p = acc << 2;
      BASE_8:  p = acc << 3;
      BASE_10: p = (acc << 3) + (acc << 1);
      BASE_16: p = acc << 4;
      default: p = acc << 1;
    endcase
    return p + {59'd0, d};
  endfunction

endpackage

[design/multibase_integer_literal_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibase_integer_literal_parser
// Parses integer literal tokens with optional base prefix, one char per cycle.
// ----------------------------------------------------------------------------
// result: a token's last char is held in the input register, and its result is then registered in the output register
// throughput: one char per cycle, set by the single input and output register
// a full output register with out_ready low stalls only a token's last char
// reset: synchronous active-low rst_n clears valids and token state and sets
// default_base to 10; no clearing pass
module multibase_integer_literal_parser
  import mblp_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam int PW = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_TOKEN_LEN);

  logic [4:0]    dflt_base_r;
  logic          in_vld_r;
  in_item_t      in_r;
  logic          out_vld_r;
  out_item_t     out_r;
  out_item_t     out_nxt;

  phase_t        phase_r, phase_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [2:0]    base_r, base_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          sfx_seen_r, sfx_seen_nxt;
  logic [PW-1:0] sfx_pos_r, sfx_pos_nxt;
  logic [1:0]    kind_r, kind_nxt;

  logic          advance;
  logic [2:0]    dflt_code;
  logic          take;
  logic [2:0]    take_base;
  logic [4:0]    digit;
  logic [PW+7:0] sfx_pos_ext;

  assign advance   = in_vld_r && (!in_r.last_char || !out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign dflt_code = code_of_radix(dflt_base_r);
  assign digit     = digit_of(in_r.ch);

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    base_nxt     = base_r;
    pos_nxt      = pos_r;
    sfx_seen_nxt = sfx_seen_r;
    sfx_pos_nxt  = sfx_pos_r;
    kind_nxt     = kind_r;
    take         = 1'b0;
    out_nxt      = '0;

    unique case (phase_r)
      PH_START: begin
        if (in_r.ch == CH_QUOTE) begin
          phase_nxt = PH_STRING;
          kind_nxt  = KIND_STRING;
        end else if (in_r.ch == CH_0) begin
          phase_nxt = PH_ZERO;
          kind_nxt  = KIND_NUMBER;
        end else if (in_r.ch >= CH_1 && in_r.ch <= CH_9) begin
          if (dflt_code == BASE_NONE) begin
            phase_nxt = PH_UNSUP;
            kind_nxt  = KIND_UNSUP;
          end else begin
            base_nxt  = dflt_code;
            phase_nxt = PH_NUMBER;
            kind_nxt  = KIND_NUMBER;
            take      = 1'b1;
          end
        end else begin
          phase_nxt = PH_NONNUM;
          kind_nxt  = KIND_NONNUM;
        end
      end
      PH_ZERO: begin
        if (in_r.ch == CH_X) begin
          base_nxt  = BASE_16;
          phase_nxt = PH_NUMBER;
        end else if (in_r.ch == CH_B) begin
          base_nxt  = BASE_2;
          phase_nxt = PH_NUMBER;
        end else if (in_r.ch == CH_O) begin
          base_nxt  = BASE_8;
          phase_nxt = PH_NUMBER;
        end else if (in_r.ch == CH_D) begin
          base_nxt  = BASE_10;
          phase_nxt = PH_NUMBER;
        end else if (in_r.ch == CH_Q) begin
          base_nxt  = BASE_4;
          phase_nxt = PH_NUMBER;
        end else if (dflt_code == BASE_NONE) begin
          phase_nxt = PH_UNSUP;
          kind_nxt  = KIND_UNSUP;
        end else begin
          base_nxt  = dflt_code;
          phase_nxt = PH_NUMBER;
          kind_nxt  = KIND_NUMBER;
          take      = 1'b1;
        end
      end
      PH_NUMBER: take = 1'b1;
      default: ;
    endcase

    take_base = (base_nxt < BASE_NONE) ? base_nxt : BASE_2;
    if (take) begin
      if (digit < radix_of_code(take_base)) begin
        acc_nxt = mul_add(acc_r, take_base, digit);
      end else begin
        sfx_seen_nxt = 1'b1;
        sfx_pos_nxt  = pos_r;
        phase_nxt    = PH_SUFFIX;
      end
    end

    // lone zero resolves against the default base
    if (in_r.last_char && phase_nxt == PH_ZERO) begin
      if (dflt_code == BASE_NONE) begin
        kind_nxt = KIND_UNSUP;
      end else begin
        base_nxt = dflt_code;
        kind_nxt = KIND_NUMBER;
      end
    end

    sfx_pos_ext = {8'd0, sfx_pos_nxt};
    if (kind_nxt == KIND_NUMBER) begin
      out_nxt.value      = acc_nxt;
      out_nxt.kind       = KIND_NUMBER;
      out_nxt.base_used  = base_nxt;
      out_nxt.has_suffix = sfx_seen_nxt;
      if (sfx_seen_nxt) begin
        out_nxt.suffix_start = (sfx_pos_ext > (PW+8)'(255)) ? 8'hff : sfx_pos_ext[7:0];
      end
    end else begin
      out_nxt.kind = kind_nxt;
    end

    if (in_r.last_char) begin
      phase_nxt    = PH_START;
      acc_nxt      = '0;
      base_nxt     = BASE_2;
      pos_nxt      = '0;
      sfx_seen_nxt = 1'b0;
      sfx_pos_nxt  = '0;
      kind_nxt     = KIND_NUMBER;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_base_r <= DEFAULT_BASE_RST;
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      phase_r     <= PH_START;
      acc_r       <= '0;
      base_r      <= BASE_2;
      pos_r       <= '0;
      sfx_seen_r  <= 1'b0;
      sfx_pos_r   <= '0;
      kind_r      <= KIND_NUMBER;
    end else begin
      if (cfg_wr_en) begin
        dflt_base_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance && in_r.last_char) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (advance) begin
        phase_r    <= phase_nxt;
        acc_r      <= acc_nxt;
        base_r     <= base_nxt;
        pos_r      <= pos_nxt;
        sfx_seen_r <= sfx_seen_nxt;
        sfx_pos_r  <= sfx_pos_nxt;
        kind_r     <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance && in_r.last_char) begin
      out_r <= out_nxt;
    end
  end

  a_nonnum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_NUMBER |->
      out_data.value == 64'd0 && out_data.base_used == BASE_2 &&
      !out_data.has_suffix && out_data.suffix_start == 8'd0)
    else $error("non-number result carries nonzero fields");

  a_no_sfx_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_suffix |-> out_data.suffix_start == 8'd0)
    else $error("suffix position without suffix");

  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.base_used <= BASE_16)
    else $error("base code out of range");

  a_token_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.last_char |=>
      phase_r == PH_START && pos_r == '0 && acc_r == 64'd0 && out_vld_r)
    else $error("token state not cleared after last transaction");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX && sfx_pos_r <= POS_MAX)
    else $error("position counter beyond saturation");

endmodule
